/* rtl/gsh_pkg.sv */
// Shared types and codes for the group switch handshake unit.
// No dependencies; every other file refers to it by scoped names.
package gsh_pkg;

   localparam int unsigned TreeWidth = 32;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned SeqWidth = 32;
   localparam int unsigned AttemptWidth = 3;

   localparam logic [AttemptWidth-1:0] MaxAttempts = 3'd3;
   localparam logic [TimeWidth-1:0] RetryTimeoutReset = 32'd1000000;

   // input action codes
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_SWITCH = 2'd1;
   localparam logic [1:0] ACT_REPLY = 2'd2;

   // reply kind and mode codes
   localparam logic [1:0] KIND_LEAVE = 2'd0;
   localparam logic [1:0] KIND_JOIN = 2'd1;
   localparam logic [1:0] MODE_POSITIVE = 2'd0;
   localparam logic [1:0] MODE_NEGATIVE = 2'd1;

   // request codes
   localparam logic [1:0] REQ_NONE = 2'd0;
   localparam logic [1:0] REQ_LEAVE = 2'd1;
   localparam logic [1:0] REQ_JOIN = 2'd2;

   // outcome codes
   localparam logic [1:0] OUT_NONE = 2'd0;
   localparam logic [1:0] OUT_SUCCESS = 2'd1;
   localparam logic [1:0] OUT_ABANDON = 2'd2;

   // handshake phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LEAVING = 2'd1;
   localparam logic [1:0] PH_JOINING = 2'd2;

   typedef struct packed {
      logic [1:0]           action;
      logic [TimeWidth-1:0] now;
      logic [TreeWidth-1:0] wanted_tree;
      logic [1:0]           reply_kind;
      logic [1:0]           reply_mode;
   } event_type;

   typedef struct packed {
      logic [1:0]           send_request;
      logic                 request_retry;
      logic [SeqWidth-1:0]  request_seq;
      logic [TreeWidth-1:0] request_tree;
      logic                 drop_all_subs;
      logic                 add_view_subs;
      logic [1:0]           outcome;
      logic                 busy_res;
      logic [TreeWidth-1:0] active_tree;
   } result_type;

endpackage

/* rtl/gsh_in_reg.sv */
// Input register for the group switch handshake unit.
// Holds one accepted event until the core consumes it. Uses gsh_pkg.
module gsh_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  gsh_pkg::event_type  in_event,
   input  logic                consume,
   output logic                held_valid,
   output gsh_pkg::event_type  held_event
);

   logic               valid_ff, valid_in;
   gsh_pkg::event_type event_ff;

   // take a new event when empty or when the held one leaves this cycle
   assign in_ready = !valid_ff || consume;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         event_ff <= in_event;
      end
   end

   assign held_valid = valid_ff;
   assign held_event = event_ff;

endmodule

/* rtl/gsh_core.sv */
// Handshake state and combinational step logic of the group switch unit.
// Commits the state update when the event advances. Uses gsh_pkg.
module gsh_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [gsh_pkg::TimeWidth-1:0]         csr_wr_data,
   input  logic                                  advance,
   input  gsh_pkg::event_type                    ev,
   output gsh_pkg::result_type                   result
);

   logic [1:0]                          phase_ff, phase_in, phase_eff;
   logic [gsh_pkg::TreeWidth-1:0]       current_ff, current_in;
   logic [gsh_pkg::TreeWidth-1:0]       pending_ff, pending_in;
   logic [gsh_pkg::TimeWidth-1:0]       sent_ff, sent_in;
   logic [gsh_pkg::AttemptWidth-1:0]    attempts_ff, attempts_in;
   logic [gsh_pkg::SeqWidth-1:0]        seq_ff, seq_in, seq_next;
   logic [gsh_pkg::TimeWidth-1:0]       timeout_ff;
   logic [gsh_pkg::TimeWidth-1:0]       elapsed;
   gsh_pkg::result_type                 res;

   assign seq_next = seq_ff + 1'b1;
   assign elapsed = ev.now - sent_ff;
   // an unused phase code behaves as idle
   assign phase_eff = (phase_ff == gsh_pkg::PH_LEAVING || phase_ff == gsh_pkg::PH_JOINING)
                      ? phase_ff : gsh_pkg::PH_IDLE;

   always_comb begin
      phase_in = phase_eff;
      current_in = current_ff;
      pending_in = pending_ff;
      sent_in = sent_ff;
      attempts_in = attempts_ff;
      seq_in = seq_ff;
      res = '0;
      res.send_request = gsh_pkg::REQ_NONE;
      res.outcome = gsh_pkg::OUT_NONE;
      case (ev.action)
         gsh_pkg::ACT_SWITCH: begin
            if (ev.wanted_tree != '0 && ev.wanted_tree != current_ff) begin
               pending_in = ev.wanted_tree;
               sent_in = ev.now;
               attempts_in = gsh_pkg::AttemptWidth'(1);
               seq_in = seq_next;
               res.request_seq = seq_next;
               if (current_ff != '0) begin
                  res.drop_all_subs = 1'b1;
                  res.send_request = gsh_pkg::REQ_LEAVE;
                  res.request_tree = current_ff;
                  phase_in = gsh_pkg::PH_LEAVING;
               end else begin
                  current_in = ev.wanted_tree;
                  res.send_request = gsh_pkg::REQ_JOIN;
                  res.request_tree = ev.wanted_tree;
                  phase_in = gsh_pkg::PH_JOINING;
               end
            end
         end
         gsh_pkg::ACT_TICK: begin
            if (phase_eff != gsh_pkg::PH_IDLE && elapsed >= timeout_ff) begin
               if (attempts_ff > gsh_pkg::MaxAttempts) begin
                  phase_in = gsh_pkg::PH_IDLE;
                  res.outcome = gsh_pkg::OUT_ABANDON;
               end else begin
                  // resend keeps the last sequence number
                  res.send_request = (phase_eff == gsh_pkg::PH_LEAVING) ? gsh_pkg::REQ_LEAVE
                                                                        : gsh_pkg::REQ_JOIN;
                  res.request_retry = 1'b1;
                  res.request_seq = seq_ff;
                  res.request_tree = current_ff;
                  sent_in = ev.now;
                  attempts_in = attempts_ff + 1'b1;
               end
            end
         end
         gsh_pkg::ACT_REPLY: begin
            if (phase_eff == gsh_pkg::PH_LEAVING && ev.reply_kind == gsh_pkg::KIND_LEAVE) begin
               if (ev.reply_mode == gsh_pkg::MODE_POSITIVE) begin
                  current_in = pending_ff;
                  res.send_request = gsh_pkg::REQ_JOIN;
                  res.request_seq = seq_next;
                  res.request_tree = pending_ff;
                  seq_in = seq_next;
                  phase_in = gsh_pkg::PH_JOINING;
                  sent_in = ev.now;
                  attempts_in = gsh_pkg::AttemptWidth'(1);
               end else if (ev.reply_mode == gsh_pkg::MODE_NEGATIVE) begin
                  phase_in = gsh_pkg::PH_IDLE;
                  res.outcome = gsh_pkg::OUT_ABANDON;
               end
            end else if (phase_eff == gsh_pkg::PH_JOINING &&
                         ev.reply_kind == gsh_pkg::KIND_JOIN) begin
               if (ev.reply_mode == gsh_pkg::MODE_POSITIVE) begin
                  res.add_view_subs = 1'b1;
                  phase_in = gsh_pkg::PH_IDLE;
                  res.outcome = gsh_pkg::OUT_SUCCESS;
               end else if (ev.reply_mode == gsh_pkg::MODE_NEGATIVE) begin
                  phase_in = gsh_pkg::PH_IDLE;
                  res.outcome = gsh_pkg::OUT_ABANDON;
               end
            end
         end
         default: begin
         end
      endcase
      res.busy_res = (phase_in != gsh_pkg::PH_IDLE);
      res.active_tree = current_in;
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gsh_pkg::PH_IDLE;
         current_ff <= '0;
         pending_ff <= '0;
         sent_ff <= '0;
         attempts_ff <= '0;
         seq_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         current_ff <= current_in;
         pending_ff <= pending_in;
         sent_ff <= sent_in;
         attempts_ff <= attempts_in;
         seq_ff <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= gsh_pkg::RetryTimeoutReset;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   a_send_means_busy: assert property (@(posedge clock) disable iff (reset)
      advance && res.send_request != gsh_pkg::REQ_NONE |-> res.busy_res)
      else $error("request sent while handshake reports idle");

   a_outcome_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && res.outcome != gsh_pkg::OUT_NONE |=> phase_ff == gsh_pkg::PH_IDLE)
      else $error("completion did not return handshake to idle");

   a_attempts_bounded: assert property (@(posedge clock) disable iff (reset)
      attempts_ff <= gsh_pkg::MaxAttempts + 1'b1)
      else $error("attempt count exceeded limit");

   a_retry_keeps_seq: assert property (@(posedge clock) disable iff (reset)
      advance && res.request_retry |=> seq_ff == $past(seq_ff))
      else $error("resend advanced the sequence number");

endmodule

/* rtl/gsh_out_reg.sv */
// Result register for the group switch handshake unit.
// Holds one result until the consumer takes it. Uses gsh_pkg.
module gsh_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  gsh_pkg::result_type  load_result,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gsh_pkg::result_type  out_result,
   output logic                 can_load
);

   logic                valid_ff, valid_in;
   gsh_pkg::result_type result_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign out_valid = valid_ff;
   assign out_result = result_ff;

endmodule

/* rtl/group_switch_handshake_unit.sv */
// Leave-then-join tree switch handshake. Every event (tick, switch command or
// control reply) yields exactly one result. An accepted event is registered in
// the input register, is evaluated by combinational step logic and is loaded
// into the result register when that register has room. A new event can be
// taken every cycle while the result register drains; the only limit on rate
// is the consumer draining the result register. retry_timeout is written
// through csr_wr_en / csr_wr_data, which should only be used while no event is in
// flight.
module group_switch_handshake_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [gsh_pkg::TimeWidth-1:0]     csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [gsh_pkg::TimeWidth-1:0]     req_now,
   input  logic [gsh_pkg::TreeWidth-1:0]     req_wanted_tree,
   input  logic [1:0]                        req_reply_kind,
   input  logic [1:0]                        req_reply_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_send_request,
   output logic                              rsp_request_retry,
   output logic [gsh_pkg::SeqWidth-1:0]      rsp_request_seq,
   output logic [gsh_pkg::TreeWidth-1:0]     rsp_request_tree,
   output logic                              rsp_drop_all_subs,
   output logic                              rsp_add_view_subs,
   output logic [1:0]                        rsp_outcome,
   output logic                              rsp_busy_res,
   output logic [gsh_pkg::TreeWidth-1:0]     rsp_active_tree
);

   gsh_pkg::event_type  in_event, held_event;
   gsh_pkg::result_type step_result, out_result;
   logic                held_valid, can_load, advance;

   assign in_event.action = req_action;
   assign in_event.now = req_now;
   assign in_event.wanted_tree = req_wanted_tree;
   assign in_event.reply_kind = req_reply_kind;
   assign in_event.reply_mode = req_reply_mode;

   // step the event when the result register has room
   assign advance = held_valid && can_load;

   gsh_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_event   (in_event),
      .consume    (advance),
      .held_valid (held_valid),
      .held_event (held_event)
   );

   gsh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .ev          (held_event),
      .result      (step_result)
   );

   gsh_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .load_result (step_result),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_result  (out_result),
      .can_load    (can_load)
   );

   assign rsp_send_request = out_result.send_request;
   assign rsp_request_retry = out_result.request_retry;
   assign rsp_request_seq = out_result.request_seq;
   assign rsp_request_tree = out_result.request_tree;
   assign rsp_drop_all_subs = out_result.drop_all_subs;
   assign rsp_add_view_subs = out_result.add_view_subs;
   assign rsp_outcome = out_result.outcome;
   assign rsp_busy_res = out_result.busy_res;
   assign rsp_active_tree = out_result.active_tree;

endmodule
